// ===== design/aws_pkg.sv =====
// Shared constants, types and the CORDIC angle table of the arctangent waveshaper.
// Used by every module of the block and by its port checker; depends on nothing.
package aws_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int ATAN_STEPS   = 16;
    localparam int TABLE_LEN    = 24;
    localparam int CORDIC_STEPS = (ATAN_STEPS < TABLE_LEN) ? ATAN_STEPS : TABLE_LEN;

    localparam int GAIN_FRAC  = 8;
    localparam int GAIN_W     = 17;
    localparam int SCALE_W    = 16;
    localparam int OUT_W      = 17;
    localparam int ANGLE_FRAC = 30;

    localparam int MAG_W  = SAMPLE_WIDTH;
    localparam int YMAG_W = MAG_W + GAIN_W;
    localparam int XY_W   = YMAG_W + 3;
    localparam int Z_W    = 33;
    localparam int ANG_W  = 31;
    localparam int PROD_W = ANG_W + SCALE_W;

    localparam int IN_BYTES_W  = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int OUT_BYTES_W = ((OUT_W + 7) / 8) * 8;

    localparam logic [ANG_W-1:0]  HALF_PI_Q30 = 31'd1686629713;
    localparam logic [OUT_W-1:0]  OUT_MAX     = 17'd65535;
    localparam logic [PROD_W-1:0] ROUND_HALF  = PROD_W'(1) << (ANGLE_FRAC - 1);

    localparam logic [GAIN_W-1:0]  GAIN_RESET  = 17'd362;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd32768;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = GAIN_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INPUT_GAIN   = 1'b0,
        CFG_OUTPUT_SCALE = 1'b1
    } t_cfg_index;

    typedef struct packed {
        logic              neg;
        logic [YMAG_W-1:0] ymag;
    } t_front_word;

    typedef struct packed {
        logic                   neg;
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } t_cordic_word;

    // atan(2^-i) in Q1.30, truncated.
    function automatic logic [ANG_W-1:0] atan_entry(input int unsigned idx);
        logic [ANG_W-1:0] val;
        unique case (idx)
            0:       val = 31'd843314856;
            1:       val = 31'd497837829;
            2:       val = 31'd263043836;
            3:       val = 31'd133525158;
            4:       val = 31'd67021686;
            5:       val = 31'd33543515;
            6:       val = 31'd16775850;
            7:       val = 31'd8388437;
            8:       val = 31'd4194282;
            9:       val = 31'd2097149;
            10:      val = 31'd1048575;
            11:      val = 31'd524287;
            12:      val = 31'd262143;
            13:      val = 31'd131071;
            14:      val = 31'd65535;
            15:      val = 31'd32767;
            16:      val = 31'd16383;
            17:      val = 31'd8191;
            18:      val = 31'd4095;
            19:      val = 31'd2047;
            20:      val = 31'd1023;
            21:      val = 31'd511;
            22:      val = 31'd255;
            23:      val = 31'd127;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

// ===== design/aws_front.sv =====
// Front end of the arctangent waveshaper: sign split, magnitude and drive gain multiply.
// Two register stages; uses aws_pkg.
module aws_front (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    input  logic signed [aws_pkg::SAMPLE_WIDTH-1:0] i_sample,
    input  logic [aws_pkg::GAIN_W-1:0]            i_gain,
    input  logic                                  i_next_ready,
    output logic                                  o_ready,
    output logic                                  o_valid,
    output aws_pkg::t_front_word                  o_word
);

    logic                        r_va;
    logic                        r_neg;
    logic [aws_pkg::MAG_W-1:0]   r_mag;
    logic                        r_vb;
    aws_pkg::t_front_word        r_word;

    logic                        en_a;
    logic                        en_b;
    logic [aws_pkg::MAG_W-1:0]   n_mag;
    aws_pkg::t_front_word        n_word;

    assign en_b = !r_vb || i_next_ready;
    assign en_a = !r_va || en_b;

    always_comb begin
        if (i_sample[aws_pkg::SAMPLE_WIDTH-1]) begin
            n_mag = ~$unsigned(i_sample) + aws_pkg::MAG_W'(1);
        end else begin
            n_mag = $unsigned(i_sample);
        end
        n_word.neg  = r_neg;
        n_word.ymag = aws_pkg::YMAG_W'(r_mag) * aws_pkg::YMAG_W'(i_gain);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            if (en_a) begin
                r_va <= i_valid;
            end
            if (en_b) begin
                r_vb <= r_va;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_neg <= i_sample[aws_pkg::SAMPLE_WIDTH-1];
            r_mag <= n_mag;
        end
        if (en_b) begin
            r_word <= n_word;
        end
    end

    assign o_ready = en_a;
    assign o_valid = r_vb;
    assign o_word  = r_word;

endmodule

// ===== design/aws_cordic.sv =====
// Vectoring CORDIC of the arctangent waveshaper, one register stage per iteration.
// Uses the angle table and word types of aws_pkg.
module aws_cordic (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  aws_pkg::t_front_word  i_word,
    input  logic                  i_next_ready,
    output logic                  o_ready,
    output logic                  o_valid,
    output aws_pkg::t_cordic_word o_word
);

    localparam int N = aws_pkg::CORDIC_STEPS;

    logic                  r_v [N];
    aws_pkg::t_cordic_word r_w [N];
    logic [N:0]            en;
    aws_pkg::t_cordic_word w_in;

    always_comb begin
        w_in.neg = i_word.neg;
        w_in.x   = aws_pkg::XY_W'(1) << (aws_pkg::GAIN_FRAC + aws_pkg::SAMPLE_WIDTH - 1);
        w_in.y   = aws_pkg::XY_W'(i_word.ymag);
        w_in.z   = '0;
    end

    assign en[N] = i_next_ready;

    for (genvar k = 0; k < N; k++) begin : g_step
        aws_pkg::t_cordic_word         prev;
        aws_pkg::t_cordic_word         n_w;
        logic                          prev_v;
        logic signed [aws_pkg::XY_W-1:0] xs;
        logic signed [aws_pkg::XY_W-1:0] ys;
        logic signed [aws_pkg::Z_W-1:0]  ang;

        if (k == 0) begin : g_first
            assign prev   = w_in;
            assign prev_v = i_valid;
        end else begin : g_rest
            assign prev   = r_w[k-1];
            assign prev_v = r_v[k-1];
        end

        assign en[k] = !r_v[k] || en[k+1];

        always_comb begin
            xs  = prev.x >>> k;
            ys  = prev.y >>> k;
            ang = $signed({2'b00, aws_pkg::atan_entry(k)});
            n_w.neg = prev.neg;
            if (prev.y > 0) begin
                n_w.x = prev.x + ys;
                n_w.y = prev.y - xs;
                n_w.z = prev.z + ang;
            end else begin
                n_w.x = prev.x - ys;
                n_w.y = prev.y + xs;
                n_w.z = prev.z - ang;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (en[k]) begin
                r_v[k] <= prev_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en[k]) begin
                r_w[k] <= n_w;
            end
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_v[N-1];
    assign o_word  = r_w[N-1];

endmodule

// ===== design/aws_back.sv =====
// Back end of the arctangent waveshaper: angle clamp, output scale multiply,
// rounding, saturation and sign restore. Two register stages; uses aws_pkg.
module aws_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  aws_pkg::t_cordic_word          i_word,
    input  logic [aws_pkg::SCALE_W-1:0]    i_scale,
    input  logic                           i_next_ready,
    output logic                           o_ready,
    output logic                           o_valid,
    output logic signed [aws_pkg::OUT_W-1:0] o_sample
);

    logic                              r_vc;
    logic                              r_neg;
    logic [aws_pkg::PROD_W-1:0]        r_prod;
    logic                              r_vd;
    logic signed [aws_pkg::OUT_W-1:0]  r_out;

    logic                              en_c;
    logic                              en_d;
    logic [aws_pkg::ANG_W-1:0]         ang;
    logic [aws_pkg::PROD_W-1:0]        n_prod;
    logic [aws_pkg::PROD_W-1:0]        rounded;
    logic [aws_pkg::OUT_W-1:0]         mag;
    logic [aws_pkg::OUT_W-1:0]         sat;
    logic signed [aws_pkg::OUT_W-1:0]  n_out;

    assign en_d = !r_vd || i_next_ready;
    assign en_c = !r_vc || en_d;

    always_comb begin
        priority if (i_word.z < 0) begin
            ang = '0;
        end else if (i_word.z > $signed({2'b00, aws_pkg::HALF_PI_Q30})) begin
            ang = aws_pkg::HALF_PI_Q30;
        end else begin
            ang = i_word.z[aws_pkg::ANG_W-1:0];
        end
        n_prod = aws_pkg::PROD_W'(ang) * aws_pkg::PROD_W'(i_scale);

        rounded = r_prod + aws_pkg::ROUND_HALF;
        mag     = rounded[aws_pkg::ANGLE_FRAC +: aws_pkg::OUT_W];
        sat     = (mag > aws_pkg::OUT_MAX) ? aws_pkg::OUT_MAX : mag;
        n_out   = r_neg ? $signed(-sat) : $signed(sat);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc <= 1'b0;
            r_vd <= 1'b0;
        end else begin
            if (en_c) begin
                r_vc <= i_valid;
            end
            if (en_d) begin
                r_vd <= r_vc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_c) begin
            r_neg  <= i_word.neg;
            r_prod <= n_prod;
        end
        if (en_d) begin
            r_out <= n_out;
        end
    end

    assign o_ready  = en_c;
    assign o_valid  = r_vd;
    assign o_sample = r_out;

endmodule

// ===== design/arctan_waveshaper.sv =====
// Arctangent soft clipper: each signed Q1.15 sample gives atan(input_gain * x) * output_scale
// in signed Q2.15. The block takes one word per clock unless the output stalls; each word
// passes two front stages for sign split and gain multiply, one stage per CORDIC iteration
// and two back stages for the scale multiply and rounding. Each stage has its own valid bit,
// so s_axis_tready stays high as long as any stage is empty or m_axis_tready is high. The
// user must write registers through i_cfg_we, i_cfg_index and i_cfg_data only while no word
// is in flight (not enforced). Top level; instantiates aws_front, aws_cordic and aws_back.
module arctan_waveshaper (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [aws_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [aws_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [aws_pkg::IN_BYTES_W-1:0]      s_axis_tdata,  // [15:0] audio_in
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [aws_pkg::OUT_BYTES_W-1:0]     m_axis_tdata   // [16:0] audio_out, rest zero
);

    logic [aws_pkg::GAIN_W-1:0]       r_input_gain;
    logic [aws_pkg::SCALE_W-1:0]      r_output_scale;

    logic                             front_valid;
    aws_pkg::t_front_word             front_word;
    logic                             cordic_ready;
    logic                             cordic_valid;
    aws_pkg::t_cordic_word            cordic_word;
    logic                             back_ready;
    logic signed [aws_pkg::OUT_W-1:0] out_sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_input_gain   <= aws_pkg::GAIN_RESET;
            r_output_scale <= aws_pkg::SCALE_RESET;
        end else if (i_cfg_we) begin
            unique case (aws_pkg::t_cfg_index'(i_cfg_index))
                aws_pkg::CFG_INPUT_GAIN: begin
                    r_input_gain <= i_cfg_data[aws_pkg::GAIN_W-1:0];
                end
                aws_pkg::CFG_OUTPUT_SCALE: begin
                    r_output_scale <= i_cfg_data[aws_pkg::SCALE_W-1:0];
                end
            endcase
        end
    end

    aws_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .i_sample     ($signed(s_axis_tdata[aws_pkg::SAMPLE_WIDTH-1:0])),
        .i_gain       (r_input_gain),
        .i_next_ready (cordic_ready),
        .o_ready      (s_axis_tready),
        .o_valid      (front_valid),
        .o_word       (front_word)
    );

    aws_cordic u_cordic (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (front_valid),
        .i_word       (front_word),
        .i_next_ready (back_ready),
        .o_ready      (cordic_ready),
        .o_valid      (cordic_valid),
        .o_word       (cordic_word)
    );

    aws_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (cordic_valid),
        .i_word       (cordic_word),
        .i_scale      (r_output_scale),
        .i_next_ready (m_axis_tready),
        .o_ready      (back_ready),
        .o_valid      (m_axis_tvalid),
        .o_sample     (out_sample)
    );

    assign m_axis_tdata = {{(aws_pkg::OUT_BYTES_W - aws_pkg::OUT_W){1'b0}}, out_sample};

endmodule

// ===== design/aws_checker.sv =====
// Port checker for the arctangent waveshaper, attached to the top level by bind.
// Sees the top-level ports only; uses aws_pkg for widths.
module aws_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [aws_pkg::OUT_BYTES_W-1:0] m_axis_tdata
);

    // A reset cycle empties the whole pipeline.
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output word valid right after reset");

    // With no word held at the output every stage can advance.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while the output is empty");

    // A stalled output word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed or dropped under stall");

    // The padding above the sample stays zero.
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            m_axis_tdata[aws_pkg::OUT_BYTES_W-1:aws_pkg::OUT_W] == '0)
        else $error("nonzero padding in output word");

endmodule

bind arctan_waveshaper aws_checker u_aws_checker (.*);

// ===== verif/arctan_waveshaper_tb.sv =====
// Self-checking testbench for arctan_waveshaper: streams samples, predicts each shaped
// word with a CORDIC of its own and compares it with the block's output in order.
// Depends on aws_pkg and the arctan_waveshaper RTL only.
module arctan_waveshaper_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 40;

    localparam longint ATAN_Q30 [24] = '{
        843314856, 497837829, 263043836, 133525158,
        67021686, 33543515, 16775850, 8388437,
        4194282, 2097149, 1048575, 524287,
        262143, 131071, 65535, 32767,
        16383, 8191, 4095, 2047,
        1023, 511, 255, 127
    };
    localparam longint HALF_PI = 64'd1686629713;
    localparam longint MAG_LIMIT = 65535;

    logic                                i_clk;
    logic                                i_rst_n = 1'b0;
    logic                                i_cfg_we = 1'b0;
    logic [aws_pkg::CFG_IDX_W-1:0]       i_cfg_index = '0;
    logic [aws_pkg::CFG_DATA_W-1:0]      i_cfg_data = '0;
    logic                                s_axis_tvalid = 1'b0;
    logic                                s_axis_tready;
    logic [aws_pkg::IN_BYTES_W-1:0]      s_axis_tdata = '0;   // [15:0] audio_in
    logic                                m_axis_tvalid;
    logic                                m_axis_tready = 1'b0;
    logic [aws_pkg::OUT_BYTES_W-1:0]     m_axis_tdata;        // [16:0] audio_out, rest zero

    logic [aws_pkg::GAIN_W-1:0]       gain_shadow = aws_pkg::GAIN_RESET;
    logic [aws_pkg::SCALE_W-1:0]      scale_shadow = aws_pkg::SCALE_RESET;
    logic [aws_pkg::SAMPLE_WIDTH-1:0] sample_queue [$];
    logic [aws_pkg::OUT_W-1:0]        shaped_expected [$];
    int                               words_queued = 0;
    int                               words_checked = 0;
    int                               mismatches = 0;
    int                               stall_cycles = 0;
    int                               src_gap = 0;
    int                               sink_gap = 0;
    bit                               idling = 1'b1;

    arctan_waveshaper u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // Vectoring CORDIC on |gain * x| with floor shifts, then the scale multiply
    // rounded half up, magnitude saturation and the sign put back.
    function automatic logic [aws_pkg::OUT_W-1:0] shape_sample(
        logic [aws_pkg::SAMPLE_WIDTH-1:0] raw);
        longint mag;
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        longint r;
        mag = longint'(raw);
        if (raw[aws_pkg::SAMPLE_WIDTH-1]) begin
            mag = (longint'(1) << aws_pkg::SAMPLE_WIDTH) - mag;
        end
        y = mag * longint'(gain_shadow);
        x = longint'(1) << (aws_pkg::GAIN_FRAC + aws_pkg::SAMPLE_WIDTH - 1);
        z = 0;
        for (int i = 0; i < aws_pkg::CORDIC_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x = x + ys;
                y = y - xs;
                z = z + ATAN_Q30[i];
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - ATAN_Q30[i];
            end
        end
        if (z < 0) begin
            z = 0;
        end
        if (z > HALF_PI) begin
            z = HALF_PI;
        end
        r = (z * longint'(scale_shadow) + (longint'(1) << (aws_pkg::ANGLE_FRAC - 1)))
            >>> aws_pkg::ANGLE_FRAC;
        if (r > MAG_LIMIT) begin
            r = MAG_LIMIT;
        end
        if (raw[aws_pkg::SAMPLE_WIDTH-1]) begin
            r = -r;
        end
        return r[aws_pkg::OUT_W-1:0];
    endfunction

    task automatic report_mismatch(string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    always @(posedge i_clk) begin : drive_samples
        logic fire;
        fire = s_axis_tvalid && s_axis_tready;
        if (fire) begin
            shaped_expected.push_back(
                shape_sample(s_axis_tdata[aws_pkg::SAMPLE_WIDTH-1:0]));
        end
        if (!s_axis_tvalid || fire) begin
            if (src_gap > 0) begin
                src_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (idling && $urandom_range(0, 7) == 0) begin
                src_gap = $urandom_range(0, 15);
                s_axis_tvalid <= 1'b0;
            end else if (sample_queue.size() > 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= sample_queue.pop_front();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : check_words
        logic [aws_pkg::OUT_W-1:0] want;
        if (m_axis_tvalid && m_axis_tready) begin
            if (shaped_expected.size() == 0) begin
                report_mismatch($sformatf("unexpected word %h", m_axis_tdata));
            end else begin
                want = shaped_expected.pop_front();
                words_checked++;
                if (m_axis_tdata[aws_pkg::OUT_W-1:0] !== want) begin
                    report_mismatch($sformatf("audio_out got %h, want %h",
                                              m_axis_tdata[aws_pkg::OUT_W-1:0], want));
                end
                if (m_axis_tdata[aws_pkg::OUT_BYTES_W-1:aws_pkg::OUT_W] !== '0) begin
                    report_mismatch($sformatf("padding bits got %h",
                        m_axis_tdata[aws_pkg::OUT_BYTES_W-1:aws_pkg::OUT_W]));
                end
            end
        end
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap--;
            m_axis_tready <= 1'b0;
        end else if (idling && $urandom_range(0, 7) == 0) begin
            sink_gap = $urandom_range(0, 15);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (s_axis_tvalid && s_axis_tready)
            || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic write_reg(aws_pkg::t_cfg_index idx,
                             logic [aws_pkg::CFG_DATA_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == aws_pkg::CFG_INPUT_GAIN) begin
            gain_shadow = value[aws_pkg::GAIN_W-1:0];
        end else begin
            scale_shadow = value[aws_pkg::SCALE_W-1:0];
        end
    endtask

    task automatic queue_sample(logic [aws_pkg::SAMPLE_WIDTH-1:0] raw);
        sample_queue.push_back(raw);
        words_queued++;
    endtask

    task automatic wait_drained();
        while (words_checked != words_queued) begin
            @(posedge i_clk);
        end
    endtask

    function automatic logic [aws_pkg::SAMPLE_WIDTH-1:0] pick_sample();
        logic [aws_pkg::SAMPLE_WIDTH-1:0] v;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 4))
                    0: v = 16'h8000;
                    1: v = 16'h7FFF;
                    2: v = 16'h0000;
                    3: v = 16'h0001;
                    default: v = 16'hFFFF;
                endcase
            end
            1, 2: begin
                v = 16'($urandom_range(0, 512));
                if ($urandom_range(0, 1) == 1) begin
                    v = -v;
                end
            end
            default: v = 16'($urandom);
        endcase
        return v;
    endfunction

    function automatic logic [aws_pkg::GAIN_W-1:0] pick_gain();
        logic [aws_pkg::GAIN_W-1:0] g;
        case ($urandom_range(0, 5))
            0: g = 17'($urandom);
            1: begin
                case ($urandom_range(0, 2))
                    0: g = '0;
                    1: g = 17'd1;
                    default: g = '1;
                endcase
            end
            default: g = 17'($urandom_range(256, 92682));
        endcase
        return g;
    endfunction

    function automatic logic [aws_pkg::CFG_DATA_W-1:0] pick_scale();
        logic [aws_pkg::SCALE_W-1:0] k;
        case ($urandom_range(0, 5))
            0: k = 16'($urandom);
            1: begin
                case ($urandom_range(0, 2))
                    0: k = '0;
                    1: k = 16'd32768;
                    default: k = '1;
                endcase
            end
            default: k = 16'($urandom_range(7946, 32768));
        endcase
        return {1'($urandom_range(0, 1)), k};
    endfunction

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: zero, the smallest steps, both full-scale ends and bit patterns.
        queue_sample(16'h0000);
        queue_sample(16'h0001);
        queue_sample(16'hFFFF);
        queue_sample(16'h7FFF);
        queue_sample(16'h8000);
        queue_sample(16'h8001);
        queue_sample(16'h4000);
        queue_sample(16'hC000);
        queue_sample(16'h5555);
        queue_sample(16'hAAAA);
        wait_drained();

        // Largest gain overshoots the angle, and a scale above range saturates.
        write_reg(aws_pkg::CFG_INPUT_GAIN, '1);
        write_reg(aws_pkg::CFG_OUTPUT_SCALE, '1);
        queue_sample(16'h7FFF);
        queue_sample(16'h8000);
        queue_sample(16'h0001);
        queue_sample(16'hFFFF);
        queue_sample(16'h0100);
        queue_sample(16'hFF00);
        wait_drained();

        write_reg(aws_pkg::CFG_INPUT_GAIN, '0);
        write_reg(aws_pkg::CFG_OUTPUT_SCALE, '0);
        queue_sample(16'h7FFF);
        queue_sample(16'h8000);
        queue_sample(16'h1234);
        wait_drained();

        write_reg(aws_pkg::CFG_INPUT_GAIN, 17'd1);
        write_reg(aws_pkg::CFG_OUTPUT_SCALE, 17'd32768);
        queue_sample(16'h0001);
        queue_sample(16'hFFFF);
        queue_sample(16'h7FFF);
        queue_sample(16'h8000);
        wait_drained();

        for (int phase = 0; phase < 10; phase++) begin
            if (phase == 9) begin
                idling = 1'b0;
            end
            write_reg(aws_pkg::CFG_INPUT_GAIN, pick_gain());
            write_reg(aws_pkg::CFG_OUTPUT_SCALE, pick_scale());
            for (int n = 0; n < 163; n++) begin
                queue_sample(pick_sample());
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
